// File: rtl/rmd128_pkg.sv
// Shared types, constants and step tables for the RIPEMD-128 engine.
// No dependencies; imported by rmd128_step and the engine top level.
`default_nettype none
package rmd128_pkg;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_PRIME, ST_ROUND, ST_FINAL, ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_MARK, PH_FILL, PH_HI, PH_DONE
   } phase_type;

   // Four working words of one line
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } line_type;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] PAD_MARK = 32'h00000080;

   localparam logic [31:0] LEFT_K  [4] = '{32'h00000000, 32'h5A827999,
                                          32'h6ED9EBA1, 32'h8F1BBCDC};
   localparam logic [31:0] RIGHT_K [4] = '{32'h50A28BE6, 32'h5C4DD124,
                                          32'h6D703EF3, 32'h00000000};

   localparam logic [3:0] LEFT_IDX [64] = '{
      4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15,
      4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,4'd11,4'd8,
      4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,4'd5,4'd12,
      4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,4'd2};

   localparam logic [3:0] LEFT_ROT [64] = '{
      4'd11,4'd14,4'd15,4'd12,4'd5,4'd8,4'd7,4'd9,4'd11,4'd13,4'd14,4'd15,4'd6,4'd7,4'd9,4'd8,
      4'd7,4'd6,4'd8,4'd13,4'd11,4'd9,4'd7,4'd15,4'd7,4'd12,4'd15,4'd9,4'd11,4'd7,4'd13,4'd12,
      4'd11,4'd13,4'd6,4'd7,4'd14,4'd9,4'd13,4'd15,4'd14,4'd8,4'd13,4'd6,4'd5,4'd12,4'd7,4'd5,
      4'd11,4'd12,4'd14,4'd15,4'd14,4'd15,4'd9,4'd8,4'd9,4'd14,4'd5,4'd6,4'd8,4'd6,4'd5,4'd12};

   localparam logic [3:0] RIGHT_IDX [64] = '{
      4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,4'd3,4'd12,
      4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,4'd1,4'd2,
      4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,4'd4,4'd13,
      4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,4'd14};

   localparam logic [3:0] RIGHT_ROT [64] = '{
      4'd8,4'd9,4'd9,4'd11,4'd13,4'd15,4'd15,4'd5,4'd7,4'd7,4'd8,4'd11,4'd14,4'd14,4'd12,4'd6,
      4'd9,4'd13,4'd15,4'd7,4'd12,4'd8,4'd9,4'd11,4'd7,4'd7,4'd12,4'd7,4'd6,4'd15,4'd13,4'd11,
      4'd9,4'd7,4'd15,4'd11,4'd8,4'd6,4'd6,4'd14,4'd12,4'd13,4'd5,4'd14,4'd13,4'd13,4'd7,4'd5,
      4'd15,4'd5,4'd8,4'd11,4'd14,4'd14,4'd6,4'd14,4'd6,4'd9,4'd12,4'd9,4'd12,4'd5,4'd15,4'd8};

endpackage
`default_nettype wire

// File: rtl/rmd128_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none
module rmd128_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and register both reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule
`default_nettype wire

// File: rtl/rmd128_step.sv
// Shared step unit: one step of the left and the right line together.
// Depends on rmd128_pkg for tables, constants and line_type.
`default_nettype none
module rmd128_step
   import rmd128_pkg::*;
(
   input  wire logic [5:0]  step,
   input  wire line_type    left_cur,
   input  wire line_type    right_cur,
   input  wire logic [31:0] x_left,
   input  wire logic [31:0] x_right,
   output line_type         left_nxt,
   output line_type         right_nxt
);

   function automatic logic [31:0] mix(input logic [1:0] sel, input logic [31:0] x,
                                       input logic [31:0] y, input logic [31:0] z);
      logic [31:0] r;
      case (sel)
         2'd0:    r = x ^ y ^ z;
         2'd1:    r = z ^ (x & (y ^ z));
         2'd2:    r = z ^ (x | ~y);
         default: r = y ^ (z & (x ^ y));
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] v, input logic [3:0] n);
      logic [63:0] dbl;
      dbl = {v, v} << n;
      return dbl[63:32];
   endfunction

   logic [1:0]  rnd;
   logic [31:0] sum_l, sum_r, t_l, t_r;

   // Sum, rotate and shift both lines
   always_comb begin
      rnd   = step[5:4];
      sum_l = left_cur.a + mix(rnd, left_cur.b, left_cur.c, left_cur.d)
              + x_left + LEFT_K[rnd];
      sum_r = right_cur.a + mix(2'd3 - rnd, right_cur.b, right_cur.c, right_cur.d)
              + x_right + RIGHT_K[rnd];
      t_l = rotl(sum_l, LEFT_ROT[step]);
      t_r = rotl(sum_r, RIGHT_ROT[step]);
      left_nxt  = '{a: left_cur.d,  b: t_l, c: left_cur.b,  d: left_cur.c};
      right_nxt = '{a: right_cur.d, b: t_r, c: right_cur.b, d: right_cur.c};
   end

endmodule
`default_nettype wire

// File: rtl/ripemd128_hash_engine_core.sv
// RIPEMD-128 engine top level: sequencer, chaining words, block buffer, output.
// Depends on rmd128_pkg, rmd128_ram and rmd128_step.
//
// Usage: message words enter on the req_ stream, one little-endian word per
// handshake; req_tlast marks the final word, whose valid byte count (0..4)
// sits in req_tdata[34:32]. A non-final word always counts as four bytes.
// After the final word the engine pads, appends the bit length and returns
// the four digest words on the rsp_ stream, rsp_tuser giving the word index
// and rsp_tlast marking the fourth. Then it starts a new message.
// Timing: a word that does not fill a block is simply stored. A word that fills
// the block starts one compression: a priming state for the buffer's registered
// read ports, all 64 steps of the shared step unit (both lines per cycle) and a
// feed-forward state. Padding writes one word per cycle and may need one extra
// compression. req_tready is low throughout.
// Digest words are held while rsp_tready is low; no new word is taken until
// all four are delivered. Reset loads the initial chaining values and clears
// the position and the bit count.
`default_nettype none
module ripemd128_hash_engine_core
   import rmd128_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // [31:0] data_word, [34:32] valid_bytes, [39:35] zero
   input  wire logic        req_tlast,  // end_of_message
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,  // [31:0] digest_word
   output logic      [1:0]  rsp_tuser,  // [1:0] word_index
   output logic             rsp_tlast   // last_word
);

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [3:0]  pos_ff, pos_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  step_ff, step_in;
   logic [1:0]  idx_ff, idx_in;
   logic        ending_ff, ending_in;
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   line_type    left_ff, left_in, right_ff, right_in;
   line_type    left_nxt, right_nxt;

   logic        wr_en;
   logic [31:0] wr_data;
   logic [5:0]  rd_step;
   logic [31:0] x_left, x_right;
   logic        req_hs, rsp_hs;
   logic [2:0]  nb_eff;
   logic [31:0] final_word;

   rmd128_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (pos_ff),
      .wr_data   (wr_data),
      .rd_addr_a (LEFT_IDX[rd_step]),
      .rd_addr_b (RIGHT_IDX[rd_step]),
      .rd_data_a (x_left),
      .rd_data_b (x_right)
   );

   rmd128_step u_step (
      .step      (step_ff),
      .left_cur  (left_ff),
      .right_cur (right_ff),
      .x_left    (x_left),
      .x_right   (x_right),
      .left_nxt  (left_nxt),
      .right_nxt (right_nxt)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = chain_ff[idx_ff];
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == 2'd3);
   assign req_hs     = req_tvalid && req_tready;
   assign rsp_hs     = rsp_tvalid && rsp_tready;

   // Mask the final word and place the marker byte
   always_comb begin
      nb_eff = (!req_tlast || req_tdata[34:32] > 3'd4) ? 3'd4 : req_tdata[34:32];
      case (nb_eff)
         3'd0:    final_word = PAD_MARK;
         3'd1:    final_word = {16'h0000, 8'h80, req_tdata[7:0]};
         3'd2:    final_word = {8'h00, 8'h80, req_tdata[15:0]};
         3'd3:    final_word = {8'h80, req_tdata[23:0]};
         default: final_word = req_tdata[31:0];
      endcase
   end

   // Sequence accept, padding, compression and digest output
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      bits_in   = bits_ff;
      step_in   = step_ff;
      idx_in    = idx_ff;
      ending_in = ending_ff;
      chain_in  = chain_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      wr_en     = 1'b0;
      wr_data   = final_word;
      rd_step   = (state_ff == ST_ROUND) ? step_ff + 6'd1 : 6'd0;
      case (state_ff)
         ST_IDLE: begin
            if (req_hs) begin
               wr_en     = 1'b1;
               pos_in    = pos_ff + 4'd1;
               bits_in   = bits_ff + {58'd0, nb_eff, 3'b000};
               ending_in = req_tlast;
               phase_in  = (nb_eff == 3'd4) ? PH_MARK : PH_FILL;
               if (pos_ff == 4'd15) begin
                  state_in = ST_PRIME;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            wr_en  = 1'b1;
            pos_in = pos_ff + 4'd1;
            case (phase_ff)
               PH_MARK: begin
                  wr_data  = PAD_MARK;
                  phase_in = PH_FILL;
               end
               PH_FILL: begin
                  wr_data = (pos_ff == 4'd14) ? bits_ff[31:0] : 32'd0;
                  if (pos_ff == 4'd14) begin
                     phase_in = PH_HI;
                  end
               end
               PH_HI: begin
                  wr_data  = bits_ff[63:32];
                  phase_in = PH_DONE;
               end
               default: begin
                  wr_en  = 1'b0;
                  pos_in = pos_ff;
               end
            endcase
            if (pos_ff == 4'd15) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            left_in  = '{a: chain_ff[0], b: chain_ff[1], c: chain_ff[2], d: chain_ff[3]};
            right_in = left_in;
            step_in  = 6'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            left_in  = left_nxt;
            right_in = right_nxt;
            step_in  = step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            chain_in[0] = chain_ff[1] + left_ff.c + right_ff.d;
            chain_in[1] = chain_ff[2] + left_ff.d + right_ff.a;
            chain_in[2] = chain_ff[3] + left_ff.a + right_ff.b;
            chain_in[3] = chain_ff[0] + left_ff.b + right_ff.c;
            idx_in      = 2'd0;
            if (!ending_ff) begin
               state_in = ST_IDLE;
            end else if (phase_ff == PH_DONE) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (rsp_hs) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  chain_in  = '{IV0, IV1, IV2, IV3};
                  pos_in    = 4'd0;
                  bits_in   = 64'd0;
                  ending_in = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold control state; reset to the initial values
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= PH_DONE;
         pos_ff    <= 4'd0;
         bits_ff   <= 64'd0;
         step_ff   <= 6'd0;
         idx_ff    <= 2'd0;
         ending_ff <= 1'b0;
         chain_ff  <= '{IV0, IV1, IV2, IV3};
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         bits_ff   <= bits_in;
         step_ff   <= step_in;
         idx_ff    <= idx_in;
         ending_ff <= ending_in;
         chain_ff  <= chain_in;
      end
   end

   // Advance the working words of both lines
   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   a_no_take_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while digest pending");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_hs && idx_ff == 2'd3) |=> (state_ff == ST_IDLE && pos_ff == 4'd0
                                      && bits_ff == 64'd0 && chain_ff[0] == IV0))
      else $error("engine not restarted after digest");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && step_ff == 6'd63) |=> state_ff == ST_FINAL)
      else $error("compression did not end after 64 steps");

   a_out_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == ST_FINAL && idx_ff == 2'd0))
      else $error("digest output without finished compression");

endmodule
`default_nettype wire
